/* rtl/rtt_pkg.sv */
`timescale 1ns / 1ps

package rtt_pkg;

   localparam int ENTRIES       = 16;
   localparam int KEY_BITS      = 32;
   localparam int IN_KEY_BITS   = 32;
   localparam int KEY_W         = (KEY_BITS < IN_KEY_BITS) ? KEY_BITS : IN_KEY_BITS;
   localparam int IDX_BITS      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS      = $clog2(ENTRIES + 1);
   localparam int TIME_BITS     = 32;
   localparam int ATT_BITS      = 8;
   localparam int INTERVAL_BITS = 31;
   localparam int TRK_BITS      = 5;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      CMD_BEGIN_SCAN = 2'd0,
      CMD_SEE        = 2'd1,
      CMD_END_SCAN   = 2'd2,
      CMD_QUERY      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_STATUS     = 2'd0,
      ACT_RETRANSMIT = 2'd1,
      ACT_FAILED     = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RETRIES_EN       = 3'd0,
      CSR_RESET_PATH_EN    = 3'd1,
      CSR_RETRY_INTERVAL   = 3'd2,
      CSR_MAX_RETRIES      = 3'd3,
      CSR_RESET_PATH_AFTER = 3'd4
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STATUS
   } state_type;

endpackage

/* rtl/retry_tracking_table.sv */
`timescale 1ns / 1ps

// Retry tracking table for pending outgoing messages.
// A command item is taken at a clock edge where start is high and busy is low.
// begin_scan clears all seen marks; see marks or claims an entry; end_scan frees
// unseen entries and, when retries are enabled, fails or retransmits due ones;
// query reports the attempts recorded for a key.
// Results come out on the rsp_ ports for one cycle each, marked by rsp_valid.
// The receiver cannot stall them. Every command closes with a status item that
// has rsp_last set and carries the tracked count.
// A single entry compare and time subtract unit walks the table one entry per
// cycle. see, query and end_scan walk up to ENTRIES entries and then pass
// through a status state (a see or query hit stops the walk early); begin_scan
// skips the walk. A new item is taken only once busy falls after the status state.
// A retransmit or failure item appears in the cycle after its entry is visited,
// and the status item in the cycle after the status state.
// Configuration writes on the csr_ channel are always ready and should be made
// only while the block is idle.
// Synchronous reset empties the table and restores the register defaults.
module retry_tracking_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_cmd,
   input  logic [31:0]                         req_msg_key,
   input  logic [31:0]                         req_sender_time,
   input  logic [31:0]                         req_now_ms,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_action,
   output logic [31:0]                         rsp_out_key,
   output logic [31:0]                         rsp_out_sender_time,
   output logic [7:0]                          rsp_attempt_count,
   output logic                                rsp_reset_path,
   output logic                                rsp_found,
   output logic [4:0]                          rsp_tracked_count,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rtt_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [rtt_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int E  = rtt_pkg::ENTRIES;
   localparam int IW = rtt_pkg::IDX_BITS;
   localparam int CW = rtt_pkg::CNT_BITS;
   localparam int KW = rtt_pkg::KEY_W;
   localparam int TW = rtt_pkg::TIME_BITS;
   localparam int AW = rtt_pkg::ATT_BITS;

   rtt_pkg::state_type  state_ff, state_in;
   rtt_pkg::cmd_type    cmd_ff, cmd_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [KW-1:0]       key_ff, key_in;
   logic [TW-1:0]       stamp_ff, stamp_in;
   logic [TW-1:0]       now_ff, now_in;
   logic [TW-1:0]       next_due_ff, next_due_in;
   logic                hit_ff, hit_in;
   logic [AW-1:0]       q_att_ff, q_att_in;
   logic                free_ok_ff, free_ok_in;
   logic [IW-1:0]       free_idx_ff, free_idx_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [E-1:0]        used_ff, used_in;
   logic [E-1:0]        seen_ff, seen_in;

   logic                          retries_en_ff;
   logic                          rp_en_ff;
   logic [rtt_pkg::INTERVAL_BITS-1:0] interval_ff;
   logic [AW-1:0]                 max_retries_ff;
   logic [AW-1:0]                 rp_after_ff;

   logic [KW-1:0]       ekey_ff   [E];
   logic [TW-1:0]       estamp_ff [E];
   logic [AW-1:0]       eatt_ff   [E];
   logic [TW-1:0]       edue_ff   [E];

   logic                    rsp_valid_ff, rsp_valid_in;
   rtt_pkg::action_type     rsp_action_ff, rsp_action_in;
   logic [31:0]             rsp_key_ff, rsp_key_in;
   logic [31:0]             rsp_stamp_ff, rsp_stamp_in;
   logic [AW-1:0]           rsp_att_ff, rsp_att_in;
   logic                    rsp_rp_ff, rsp_rp_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [rtt_pkg::TRK_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                scan_last;
   logic                ent_used;
   logic                ent_seen;
   logic [AW-1:0]       ent_att;
   logic                ent_match;
   logic [TW-1:0]       due_diff;
   logic                ent_due;
   logic [AW-1:0]       att_inc;
   logic                wr_new;
   logic                wr_upd;
   logic [CW-1:0]       status_count;

   assign busy      = (state_ff != rtt_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign scan_last = (idx_ff == IW'(E - 1));
   assign ent_used  = used_ff[idx_ff];
   assign ent_seen  = seen_ff[idx_ff];
   assign ent_att   = eatt_ff[idx_ff];
   assign ent_match = ent_used && (estamp_ff[idx_ff] == stamp_ff) && (ekey_ff[idx_ff] == key_ff);
   assign due_diff  = now_ff - edue_ff[idx_ff];
   assign ent_due   = !due_diff[TW-1];
   assign att_inc   = ent_att + AW'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtt_pkg::ST_IDLE: begin
            if (accept) begin
               if (rtt_pkg::cmd_type'(req_cmd) == rtt_pkg::CMD_BEGIN_SCAN) begin
                  state_in = rtt_pkg::ST_STATUS;
               end else begin
                  state_in = rtt_pkg::ST_SCAN;
               end
            end
         end
         rtt_pkg::ST_SCAN: begin
            if (scan_last || (ent_match && (cmd_ff == rtt_pkg::CMD_SEE ||
                                            cmd_ff == rtt_pkg::CMD_QUERY))) begin
               state_in = rtt_pkg::ST_STATUS;
            end
         end
         rtt_pkg::ST_STATUS: begin
            state_in = rtt_pkg::ST_IDLE;
         end
         default: begin
            state_in = rtt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      stamp_in      = stamp_ff;
      now_in        = now_ff;
      next_due_in   = next_due_ff;
      hit_in        = hit_ff;
      q_att_in      = q_att_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      seen_in       = seen_ff;
      wr_new        = 1'b0;
      wr_upd        = 1'b0;
      status_count  = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_action_in = rsp_action_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      rsp_att_in    = rsp_att_ff;
      rsp_rp_in     = rsp_rp_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         rtt_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in      = rtt_pkg::cmd_type'(req_cmd);
               key_in      = KW'(req_msg_key);
               stamp_in    = req_sender_time;
               now_in      = req_now_ms;
               next_due_in = req_now_ms + TW'(interval_ff);
               idx_in      = '0;
               hit_in      = 1'b0;
               q_att_in    = '0;
               free_ok_in  = 1'b0;
               if (rtt_pkg::cmd_type'(req_cmd) == rtt_pkg::CMD_BEGIN_SCAN) begin
                  seen_in = '0;
               end
            end
         end
         rtt_pkg::ST_SCAN: begin
            idx_in = idx_ff + IW'(1);
            unique case (cmd_ff)
               rtt_pkg::CMD_SEE: begin
                  if (ent_match) begin
                     seen_in[idx_ff] = 1'b1;
                     hit_in          = 1'b1;
                  end else if (!ent_used && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = idx_ff;
                  end
               end
               rtt_pkg::CMD_QUERY: begin
                  if (ent_match) begin
                     hit_in   = 1'b1;
                     q_att_in = ent_att;
                  end
               end
               rtt_pkg::CMD_END_SCAN: begin
                  if (ent_used) begin
                     if (!ent_seen) begin
                        used_in[idx_ff] = 1'b0;
                        count_in        = count_ff - CW'(1);
                     end else if (retries_en_ff && ent_due) begin
                        rsp_valid_in = 1'b1;
                        rsp_key_in   = 32'(ekey_ff[idx_ff]);
                        rsp_stamp_in = estamp_ff[idx_ff];
                        rsp_found_in = 1'b0;
                        rsp_count_in = '0;
                        rsp_last_in  = 1'b0;
                        if (ent_att >= max_retries_ff) begin
                           rsp_action_in   = rtt_pkg::ACT_FAILED;
                           rsp_att_in      = ent_att;
                           rsp_rp_in       = 1'b0;
                           used_in[idx_ff] = 1'b0;
                           count_in        = count_ff - CW'(1);
                        end else begin
                           rsp_action_in = rtt_pkg::ACT_RETRANSMIT;
                           rsp_att_in    = att_inc;
                           rsp_rp_in     = rp_en_ff && (att_inc == rp_after_ff);
                           wr_upd        = 1'b1;
                        end
                     end
                  end
               end
               rtt_pkg::CMD_BEGIN_SCAN: begin
               end
            endcase
         end
         rtt_pkg::ST_STATUS: begin
            if (cmd_ff == rtt_pkg::CMD_SEE && !hit_ff && free_ok_ff) begin
               wr_new               = 1'b1;
               used_in[free_idx_ff] = 1'b1;
               seen_in[free_idx_ff] = 1'b1;
               status_count         = count_ff + CW'(1);
               count_in             = status_count;
            end
            rsp_valid_in  = 1'b1;
            rsp_action_in = rtt_pkg::ACT_STATUS;
            rsp_key_in    = 32'(key_ff);
            rsp_stamp_in  = stamp_ff;
            rsp_att_in    = q_att_ff;
            rsp_rp_in     = 1'b0;
            rsp_found_in  = (cmd_ff == rtt_pkg::CMD_QUERY) && hit_ff;
            rsp_count_in  = rtt_pkg::TRK_BITS'(status_count);
            rsp_last_in   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtt_pkg::ST_IDLE;
         used_ff      <= '0;
         seen_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         seen_ff      <= seen_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      stamp_ff      <= stamp_in;
      now_ff        <= now_in;
      next_due_ff   <= next_due_in;
      hit_ff        <= hit_in;
      q_att_ff      <= q_att_in;
      free_ok_ff    <= free_ok_in;
      free_idx_ff   <= free_idx_in;
      rsp_action_ff <= rsp_action_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_stamp_ff  <= rsp_stamp_in;
      rsp_att_ff    <= rsp_att_in;
      rsp_rp_ff     <= rsp_rp_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_new) begin
         ekey_ff[free_idx_ff]   <= key_ff;
         estamp_ff[free_idx_ff] <= stamp_ff;
         eatt_ff[free_idx_ff]   <= '0;
         edue_ff[free_idx_ff]   <= next_due_ff;
      end else if (wr_upd) begin
         eatt_ff[idx_ff] <= att_inc;
         edue_ff[idx_ff] <= next_due_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retries_en_ff  <= 1'b0;
         rp_en_ff       <= 1'b0;
         interval_ff    <= rtt_pkg::INTERVAL_BITS'(30000);
         max_retries_ff <= AW'(3);
         rp_after_ff    <= AW'(2);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rtt_pkg::CSR_RETRIES_EN:       retries_en_ff  <= csr_wdata[0];
            rtt_pkg::CSR_RESET_PATH_EN:    rp_en_ff       <= csr_wdata[0];
            rtt_pkg::CSR_RETRY_INTERVAL:   interval_ff    <= csr_wdata[rtt_pkg::INTERVAL_BITS-1:0];
            rtt_pkg::CSR_MAX_RETRIES:      max_retries_ff <= csr_wdata[AW-1:0];
            rtt_pkg::CSR_RESET_PATH_AFTER: rp_after_ff    <= csr_wdata[AW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_action          = rsp_action_ff;
   assign rsp_out_key         = rsp_key_ff;
   assign rsp_out_sender_time = rsp_stamp_ff;
   assign rsp_attempt_count   = rsp_att_ff;
   assign rsp_reset_path      = rsp_rp_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_tracked_count   = rsp_count_ff;
   assign rsp_last            = rsp_last_ff;

   a_count_matches_used: assert property (@(posedge clock) disable iff (reset)
      count_ff == CW'($countones(used_ff)))
      else $error("tracked count differs from the number of used entries");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after taking an item");

   a_status_ends_command: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (state_ff == rtt_pkg::ST_IDLE))
      else $error("closing status item while a command is still running");

   a_action_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> $past(state_ff == rtt_pkg::ST_SCAN &&
                                         cmd_ff == rtt_pkg::CMD_END_SCAN))
      else $error("action item outside an end of scan walk");

endmodule

/* bench/retry_tracking_table_tb.sv */
`timescale 1ns / 1ps

module retry_tracking_table_tb;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 45;
   localparam int SCRIPT_ROWS = 23;

   typedef struct packed {
      rtt_pkg::action_type action;
      logic [31:0]         key;
      logic [31:0]         stamp;
      logic [7:0]          attempts;
      logic                reset_path;
      logic                found;
      logic [4:0]          tracked;
      logic                last;
   } action_rec;

   typedef struct packed {
      bit                   reg_write;
      rtt_pkg::csr_reg_type reg_idx;
      rtt_pkg::cmd_type     cmd;
      logic [31:0]          key;
      logic [31:0]          stamp;
      logic [31:0]          now;
      bit                   typed;
      logic                 found;
      logic [7:0]           attempts;
      logic [4:0]           tracked;
   } script_row;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [31:0] req_msg_key;
   logic [31:0] req_sender_time;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic [1:0]  rsp_action;
   logic [31:0] rsp_out_key;
   logic [31:0] rsp_out_sender_time;
   logic [7:0]  rsp_attempt_count;
   logic        rsp_reset_path;
   logic        rsp_found;
   logic [4:0]  rsp_tracked_count;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [rtt_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [rtt_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   logic                        cfg_retries_en;
   logic                        cfg_rp_en;
   logic [30:0]                 cfg_interval;
   logic [7:0]                  cfg_max_retries;
   logic [7:0]                  cfg_rp_after;
   logic [rtt_pkg::ENTRIES-1:0] tbl_used;
   logic [rtt_pkg::ENTRIES-1:0] tbl_seen;
   logic [31:0]                 tbl_key [rtt_pkg::ENTRIES];
   logic [31:0]                 tbl_stamp [rtt_pkg::ENTRIES];
   logic [7:0]                  tbl_attempts [rtt_pkg::ENTRIES];
   logic [31:0]                 tbl_due [rtt_pkg::ENTRIES];

   action_rec predicted_actions[$];
   int        mismatches = 0;
   int        idle_cycles = 0;
   int        burst_left = 0;
   int        items_sent = 0;
   bit        gaps_on = 1'b1;

   // On register rows the key column carries the write data.
   script_row script [SCRIPT_ROWS] = '{
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0,
        1'b1, 1'b0, 8'd0, 5'd0},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_BEGIN_SCAN, ALL_ONES, ALL_ONES, ALL_ONES,
        1'b1, 1'b0, 8'd0, 5'd0},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_SEE, ALL_ONES, ALL_ONES, 32'h0,
        1'b1, 1'b0, 8'd0, 5'd1},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_SEE, 32'h0, 32'h0, ALL_ONES,
        1'b1, 1'b0, 8'd0, 5'd2},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_SEE, ALL_ONES, ALL_ONES, 32'd5,
        1'b1, 1'b0, 8'd0, 5'd2},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_QUERY, ALL_ONES, ALL_ONES, 32'h0,
        1'b1, 1'b1, 8'd0, 5'd2},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_QUERY, ALL_ONES, 32'h0, 32'h0,
        1'b1, 1'b0, 8'd0, 5'd2},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_BEGIN_SCAN, 32'h0, 32'h0, 32'h0,
        1'b1, 1'b0, 8'd0, 5'd2},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_SEE, 32'h0, 32'h0, 32'd123,
        1'b1, 1'b0, 8'd0, 5'd2},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_END_SCAN, 32'h0, 32'h0, ALL_ONES,
        1'b1, 1'b0, 8'd0, 5'd1},
      '{1'b1, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_BEGIN_SCAN, 32'h1, 32'h0, 32'h0,
        1'b0, 1'b0, 8'd0, 5'd0},
      '{1'b1, rtt_pkg::CSR_RESET_PATH_EN, rtt_pkg::CMD_BEGIN_SCAN, 32'h1, 32'h0, 32'h0,
        1'b0, 1'b0, 8'd0, 5'd0},
      '{1'b1, rtt_pkg::CSR_RETRY_INTERVAL, rtt_pkg::CMD_BEGIN_SCAN, 32'h8000_0001, 32'h0,
        32'h0, 1'b0, 1'b0, 8'd0, 5'd0},
      '{1'b1, rtt_pkg::CSR_MAX_RETRIES, rtt_pkg::CMD_BEGIN_SCAN, 32'h102, 32'h0, 32'h0,
        1'b0, 1'b0, 8'd0, 5'd0},
      '{1'b1, rtt_pkg::CSR_RESET_PATH_AFTER, rtt_pkg::CMD_BEGIN_SCAN, 32'h1, 32'h0, 32'h0,
        1'b0, 1'b0, 8'd0, 5'd0},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_BEGIN_SCAN, 32'h7, 32'h9, 32'h0,
        1'b1, 1'b0, 8'd0, 5'd1},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_SEE, 32'h0, 32'h0, 32'h0,
        1'b1, 1'b0, 8'd0, 5'd1},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_END_SCAN, 32'h0, 32'h0, 32'd29999,
        1'b0, 1'b0, 8'd0, 5'd0},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_END_SCAN, 32'h0, 32'h0, 32'd29999,
        1'b0, 1'b0, 8'd0, 5'd0},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_END_SCAN, 32'h0, 32'h0, 32'd30000,
        1'b0, 1'b0, 8'd0, 5'd0},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_QUERY, 32'h0, 32'h0, 32'd30000,
        1'b1, 1'b1, 8'd2, 5'd1},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_END_SCAN, 32'h0, 32'h0, 32'd30001,
        1'b0, 1'b0, 8'd0, 5'd0},
      '{1'b0, rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CMD_QUERY, 32'h0, 32'h0, 32'd30001,
        1'b1, 1'b0, 8'd0, 5'd0}
   };

   retry_tracking_table uut (.*);

   always #2 clock = ~clock;

   function automatic void push_action(rtt_pkg::action_type act, logic [31:0] key,
                                       logic [31:0] stamp, logic [7:0] att, logic rp,
                                       logic fnd, logic last);
      action_rec r;
      r.action = act;
      r.key = key;
      r.stamp = stamp;
      r.attempts = att;
      r.reset_path = rp;
      r.found = fnd;
      r.tracked = last ? 5'($countones(tbl_used)) : 5'd0;
      r.last = last;
      predicted_actions.push_back(r);
   endfunction

   function automatic void track_command(rtt_pkg::cmd_type cmd, logic [31:0] key,
                                         logic [31:0] stamp, logic [31:0] now);
      logic [31:0] next_due;
      logic [31:0] lag;
      logic [7:0]  att;
      logic [7:0]  q_att;
      int          hit;
      int          slot;
      int          i;
      next_due = now + {1'b0, cfg_interval};
      hit = -1;
      slot = -1;
      q_att = 8'd0;
      for (i = 0; i < rtt_pkg::ENTRIES; i++) begin
         if (hit < 0 && tbl_used[i] && tbl_stamp[i] == stamp && tbl_key[i] == key)
            hit = i;
         if (slot < 0 && !tbl_used[i])
            slot = i;
      end
      case (cmd)
         rtt_pkg::CMD_BEGIN_SCAN: tbl_seen = '0;
         rtt_pkg::CMD_SEE: begin
            if (hit >= 0) begin
               tbl_seen[hit] = 1'b1;
            end else if (slot >= 0) begin
               tbl_used[slot] = 1'b1;
               tbl_seen[slot] = 1'b1;
               tbl_key[slot] = key;
               tbl_stamp[slot] = stamp;
               tbl_attempts[slot] = 8'd0;
               tbl_due[slot] = next_due;
            end
         end
         rtt_pkg::CMD_END_SCAN: begin
            for (i = 0; i < rtt_pkg::ENTRIES; i++) begin
               lag = now - tbl_due[i];
               if (tbl_used[i] && !tbl_seen[i]) begin
                  tbl_used[i] = 1'b0;
               end else if (tbl_used[i] && cfg_retries_en && !lag[31]) begin
                  if (tbl_attempts[i] >= cfg_max_retries) begin
                     push_action(rtt_pkg::ACT_FAILED, tbl_key[i], tbl_stamp[i],
                                 tbl_attempts[i], 1'b0, 1'b0, 1'b0);
                     tbl_used[i] = 1'b0;
                  end else begin
                     att = tbl_attempts[i] + 8'd1;
                     tbl_attempts[i] = att;
                     push_action(rtt_pkg::ACT_RETRANSMIT, tbl_key[i], tbl_stamp[i], att,
                                 cfg_rp_en && att == cfg_rp_after, 1'b0, 1'b0);
                     tbl_due[i] = next_due;
                  end
               end
            end
         end
         default: begin
            if (hit >= 0)
               q_att = tbl_attempts[hit];
         end
      endcase
      push_action(rtt_pkg::ACT_STATUS, key, stamp, q_att, 1'b0,
                  cmd == rtt_pkg::CMD_QUERY && hit >= 0, 1'b1);
   endfunction

   task automatic send_command(rtt_pkg::cmd_type cmd, logic [31:0] key, logic [31:0] stamp,
                               logic [31:0] now);
      csr_valid <= 1'b0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         if (gaps_on && $urandom_range(3, 0) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(20, 1)) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_cmd <= cmd;
      req_msg_key <= key;
      req_sender_time <= stamp;
      req_now_ms <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      track_command(cmd, key, stamp, now);
   endtask

   task automatic write_reg(rtt_pkg::csr_reg_type idx, logic [31:0] value);
      logic [31:0] data;
      case (idx)
         rtt_pkg::CSR_RETRIES_EN, rtt_pkg::CSR_RESET_PATH_EN:
            data = value | ($urandom << 1);
         rtt_pkg::CSR_RETRY_INTERVAL: data = value | ($urandom << 31);
         default: data = value | ($urandom << 8);
      endcase
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         rtt_pkg::CSR_RETRIES_EN: cfg_retries_en = data[0];
         rtt_pkg::CSR_RESET_PATH_EN: cfg_rp_en = data[0];
         rtt_pkg::CSR_RETRY_INTERVAL: cfg_interval = data[30:0];
         rtt_pkg::CSR_MAX_RETRIES: cfg_max_retries = data[7:0];
         rtt_pkg::CSR_RESET_PATH_AFTER: cfg_rp_after = data[7:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      csr_valid <= 1'b0;
      while (predicted_actions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      action_rec want;
      if (!reset && rsp_valid) begin
         if (predicted_actions.size() == 0) begin
            $error("unexpected item: action %0d key %0h", rsp_action, rsp_out_key);
            mismatches++;
         end else begin
            want = predicted_actions.pop_front();
            check_field("action", want.action, rsp_action);
            check_field("out_key", want.key, rsp_out_key);
            check_field("out_sender_time", want.stamp, rsp_out_sender_time);
            check_field("attempt_count", want.attempts, rsp_attempt_count);
            check_field("reset_path", want.reset_path, rsp_reset_path);
            check_field("found", want.found, rsp_found);
            check_field("tracked_count", want.tracked, rsp_tracked_count);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      action_rec   closing;
      logic [31:0] live_key[$];
      logic [31:0] live_stamp[$];
      logic [31:0] clock_ms;
      logic [31:0] key_v;
      logic [30:0] v_interval;
      logic [7:0]  v_max;
      logic [7:0]  v_after;
      logic        v_retries;
      logic        v_rp_en;
      bit          flood;
      int          phase;
      int          target;
      int          pick;
      int          fresh;
      int          j;
      int          i;

      reset <= 1'b1;
      start <= 1'b0;
      req_cmd <= rtt_pkg::CMD_BEGIN_SCAN;
      req_msg_key <= '0;
      req_sender_time <= '0;
      req_now_ms <= '0;
      csr_valid <= 1'b0;
      csr_index <= rtt_pkg::CSR_RETRIES_EN;
      csr_wdata <= '0;
      cfg_retries_en = 1'b0;
      cfg_rp_en = 1'b0;
      cfg_interval = 31'd30000;
      cfg_max_retries = 8'd3;
      cfg_rp_after = 8'd2;
      tbl_used = '0;
      tbl_seen = '0;
      clock_ms = 32'hFFFF_F000;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         if (script[r].reg_write) begin
            wait_idle();
            write_reg(script[r].reg_idx, script[r].key);
         end else begin
            send_command(script[r].cmd, script[r].key, script[r].stamp, script[r].now);
            if (script[r].typed) begin
               closing = predicted_actions.pop_back();
               closing.found = script[r].found;
               closing.attempts = script[r].attempts;
               closing.tracked = script[r].tracked;
               predicted_actions.push_back(closing);
            end
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         flood = (phase == 0);
         gaps_on = (phase != 3);
         v_retries = $urandom_range(3, 0) != 0;
         v_rp_en = 1'($urandom_range(1, 0));
         v_interval = $urandom_range(1, 0) ? 31'($urandom_range(5000, 1))
                                           : 31'($urandom_range(32'h7FFF_FFFF, 1));
         v_max = 8'($urandom_range(4, 0));
         v_after = 8'($urandom_range(4, 1));
         case (phase)
            0: v_retries = 1'b0;
            1: begin
               v_retries = 1'b1;
               v_rp_en = 1'b1;
               v_interval = 31'd1;
               v_max = 8'd0;
               v_after = 8'd1;
            end
            2: begin
               v_retries = 1'b1;
               v_rp_en = 1'b1;
               v_interval = 31'h7FFF_FFFF;
               v_max = 8'd255;
               v_after = 8'd255;
            end
            default: ;
         endcase
         write_reg(rtt_pkg::csr_reg_type'($urandom_range(2 ** rtt_pkg::CSR_IDX_BITS - 1,
                                          rtt_pkg::CSR_RESET_PATH_AFTER + 1)), $urandom);
         write_reg(rtt_pkg::CSR_RETRIES_EN, 32'(v_retries));
         write_reg(rtt_pkg::CSR_RESET_PATH_EN, 32'(v_rp_en));
         write_reg(rtt_pkg::CSR_RETRY_INTERVAL, 32'(v_interval));
         write_reg(rtt_pkg::CSR_MAX_RETRIES, 32'(v_max));
         write_reg(rtt_pkg::CSR_RESET_PATH_AFTER, 32'(v_after));

         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            live_key.delete();
            live_stamp.delete();
            for (i = 0; i < rtt_pkg::ENTRIES; i++) begin
               if (tbl_used[i]) begin
                  live_key.push_back(tbl_key[i]);
                  live_stamp.push_back(tbl_stamp[i]);
               end
            end
            pick = $urandom_range(99, 0);
            if (pick < 8) begin
               send_command(rtt_pkg::cmd_type'($urandom_range(rtt_pkg::CMD_QUERY,
                                                              rtt_pkg::CMD_BEGIN_SCAN)),
                            $urandom, $urandom, $urandom);
            end else if (pick < 20) begin
               if (live_key.size() != 0 && $urandom_range(9, 0) < 7) begin
                  j = $urandom_range(live_key.size() - 1, 0);
                  send_command(rtt_pkg::CMD_QUERY, live_key[j], live_stamp[j], clock_ms);
               end else begin
                  send_command(rtt_pkg::CMD_QUERY, $urandom, $urandom, clock_ms);
               end
            end else begin
               send_command(rtt_pkg::CMD_BEGIN_SCAN, $urandom, $urandom, clock_ms);
               foreach (live_key[n])
                  if ($urandom_range(9, 0) < 8)
                     send_command(rtt_pkg::CMD_SEE, live_key[n], live_stamp[n], clock_ms);
               fresh = flood ? $urandom_range(8, 3) : $urandom_range(3, 0);
               repeat (fresh) begin
                  if (live_key.size() != 0 && $urandom_range(3, 0) == 0)
                     key_v = live_key[$urandom_range(live_key.size() - 1, 0)];
                  else
                     key_v = $urandom;
                  send_command(rtt_pkg::CMD_SEE, key_v, $urandom, clock_ms);
               end
               case ($urandom_range(5, 0))
                  0: ;
                  1: clock_ms += {1'b0, cfg_interval} - 32'd1;
                  2: clock_ms += {1'b0, cfg_interval};
                  3: clock_ms += {1'b0, cfg_interval} + 32'd1;
                  4: clock_ms += $urandom;
                  default: clock_ms += $urandom_range(3, 0);
               endcase
               send_command(rtt_pkg::CMD_END_SCAN, $urandom, $urandom, clock_ms);
            end
            if ($urandom_range(19, 0) == 0)
               wait_idle();
         end
      end

      start <= 1'b0;
      while (predicted_actions.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && predicted_actions.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
